/* design/stlb_pkg.sv */
package stlb_pkg;

    // Widths of the stream fields
    localparam int FUNC_W      = 2;
    localparam int DATA_W      = 32;
    localparam int POS_W       = 11;
    localparam int OUT_TDATA_W = 16;

    // Default table size
    localparam int TABLE_DEPTH_DEF = 1024;

    // Operation codes carried in the input tuser
    typedef enum logic [FUNC_W-1:0] {
        FUNC_APPEND = 2'd0,
        FUNC_QUERY  = 2'd1,
        FUNC_CLEAR  = 2'd2,
        FUNC_NOP    = 2'd3
    } t_func;

endpackage

/* design/sorted_table_lower_bound_search_top.sv */
// Sorted table with lower-bound search.
// Input channel (s_axis): tuser carries the operation (append, query, clear,
// no-op) and tdata the signed 32-bit value or key. Output channel (m_axis):
// one item per query, tuser = found flag, tdata = 1-based position.
// Append, clear and no-op are taken in the idle state and give no result; the table
// holds TABLE_DEPTH entries and an append to a full table is dropped.
// A query runs a binary search over the stored entries held in a
// single-port-read RAM: each probe is one RAM read of the midpoint
// followed by one compare that halves the range, and a last read of the
// candidate entry comes before the result; s_tready rises again in the
// cycle in which the result appears.
// The result sits in an output register; a stalled receiver holds it there
// while the next items are accepted. A further query result waits inside the
// block, with s_tready low, until the output register is free.
// Reset empties the table (count to zero) and drops any pending result;
// the RAM contents are not cleared.
module sorted_table_lower_bound_search_top
    import stlb_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [DATA_W-1:0]      i_s_tdata,   // [31:0] data_value
    input  logic [FUNC_W-1:0]      i_s_tuser,   // [1:0] func
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata,   // [10:0] position, rest zero
    output logic                   o_m_tuser    // [0] found
);

    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PROBE,
        S_CMP,
        S_CHECK
    } t_state;

    t_state                    r_state, n_state;
    logic [CNT_W-1:0]          r_count, n_count;
    logic [CNT_W-1:0]          r_base, n_base;
    logic [CNT_W-1:0]          r_len, n_len;
    logic signed [DATA_W-1:0]  r_key, n_key;
    logic                      r_out_valid, n_out_valid;
    logic                      r_found, n_found;
    logic [POS_W-1:0]          r_pos, n_pos;

    logic                      in_accept;
    logic [CNT_W-1:0]          half;
    logic [CNT_W-1:0]          mid;
    logic [CNT_W:0]            pos_wide;
    logic                      ram_we;
    logic                      ram_re;
    logic [ADDR_W-1:0]         ram_raddr;
    logic [DATA_W-1:0]         ram_rdata;
    logic signed [DATA_W-1:0]  entry;
    logic                      out_free;

    stlb_ram #(
        .DEPTH  (TABLE_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[ADDR_W-1:0]),
        .i_wdata (i_s_tdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign in_accept = i_s_tvalid && o_s_tready;
    assign half      = r_len >> 1;
    assign mid       = r_base + half;
    assign pos_wide  = {1'b0, r_base} + {{CNT_W{1'b0}}, 1'b1};
    assign entry     = ram_rdata;
    assign out_free  = !r_out_valid || i_m_tready;

    // Next state: append and clear straight from idle, query walks the halving loop
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_base      = r_base;
        n_len       = r_len;
        n_key       = r_key;
        n_out_valid = r_out_valid && !i_m_tready;
        n_found     = r_found;
        n_pos       = r_pos;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_raddr   = mid[ADDR_W-1:0];
        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    case (t_func'(i_s_tuser))
                        FUNC_APPEND: begin
                            if (r_count < CNT_W'(TABLE_DEPTH)) begin
                                ram_we  = 1'b1;
                                n_count = r_count + 1'b1;
                            end
                        end
                        FUNC_QUERY: begin
                            n_key   = i_s_tdata;
                            n_base  = '0;
                            n_len   = r_count;
                            n_state = S_PROBE;
                        end
                        FUNC_CLEAR: begin
                            n_count = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_PROBE: begin
                // Read the midpoint, or the final candidate once the range is empty
                ram_re = 1'b1;
                if (r_len == '0) begin
                    ram_raddr = r_base[ADDR_W-1:0];
                    n_state   = S_CHECK;
                end else begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                // Halve the range on the compare result
                if (entry < r_key) begin
                    n_base = mid + 1'b1;
                    n_len  = r_len - half - 1'b1;
                end else begin
                    n_len = half;
                end
                n_state = S_PROBE;
            end
            S_CHECK: begin
                // Hold the result here until the output register is free
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_found     = (r_base < r_count) && (entry == r_key);
                    n_pos       = POS_W'(pos_wide);
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state, count, search registers and the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_base  <= n_base;
        r_len   <= n_len;
        r_key   <= n_key;
        r_found <= n_found;
        r_pos   <= n_pos;
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_TDATA_W'(r_pos);
    assign o_m_tuser  = r_found;

    // The count never passes the table size
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TABLE_DEPTH))
        else $error("entry count beyond table size");

    // The search range stays inside the valid entries
    a_range_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PROBE || r_state == S_CMP) |->
            ({1'b0, r_base} + {1'b0, r_len}) <= {1'b0, r_count})
        else $error("search range past entry count");

    // A match inside the stored entries is always reported as a hit
    a_hit_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK && out_free && entry == r_key && r_base < r_count) |=>
            (o_m_tvalid && o_m_tuser))
        else $error("hit not reported");

    // No accepted item while a search is running
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |=> (r_state == S_PROBE && !in_accept))
        else $error("item accepted during search");

endmodule

/* design/stlb_ram.sv */
module stlb_ram
    import stlb_pkg::*;
#(
    parameter int DEPTH  = TABLE_DEPTH_DEF,
    parameter int ADDR_W = 10
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    // Write one entry, read one entry with a registered output
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
